>>> rtl/strict_priority_multi_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strict priority multi queue unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_QUEUE_UNIT_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_UNIT_DEFINES_SVH

// The property must hold at every rising clock edge out of reset.
`define SPMQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spmq assertion failed");

// The condition must never be true at a rising clock edge out of reset.
`define SPMQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("spmq forbidden condition seen");

`endif

>>> rtl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority multi queue package
// Sizes, codes, payload structs and controller commands shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spmq_pkg;

  // Queue organization.
  localparam int QUEUE_COUNT = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_COUNT  = QUEUE_COUNT * QUEUE_DEPTH;

  // Derived widths.
  localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CAP_W  = 5;
  localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int QOUT_W = 2;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_CLOSE  = 2'd2
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_CLOSED = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // One request item.
  typedef struct packed {
    logic [1:0]          action;
    logic signed [7:0]   priority_req;
    logic signed [31:0]  task_id;
    logic [31:0]         work_ref;
    logic [31:0]         work_arg;
  } spmq_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]          status;
    logic [QOUT_W-1:0]   queue_index;
    logic signed [31:0]  out_task_id;
    logic [31:0]         out_work_ref;
    logic [31:0]         out_work_arg;
    logic                drained;
  } spmq_out_t;

  // One stored task.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] wref;
    logic [31:0] warg;
  } task_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } spmq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/strict_priority_multi_queue_unit.sv
// ----------------------------------------------------------------------------
// Strict priority multi queue unit
// Bounded FIFO task queues, one per priority level, with submit/take/close.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start_i high and busy_o low.
//   Submit clamps priority_req to a queue and appends the task if that
//   queue is below capacity; take pops the oldest task of the highest
//   non-empty queue; close refuses all later submits while takes drain.
//   Each request yields one result, shown on result_o for exactly one
//   cycle with done_o high; the result transfers at the edge ending that
//   cycle and the receiver cannot stall it.
//   Each request passes through the execute cycle, which updates the
//   queues and reads the task memory into a register, and then the
//   result cycle, in which the result is on the ports. busy_o is high
//   in the execute cycle, so no request transfers then; the next
//   request may transfer while the previous result is on the ports.
//   The capacity register transfers when cfg_valid_i and cfg_ready_o are
//   high; cfg_ready_o is always high. Write it only while idle.
//   Reset empties all queues, reopens the unit and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_multi_queue_unit
  import spmq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire spmq_in_t         req_i,
  output logic                  done_o,
  output spmq_out_t             result_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i
);

  spmq_cmd_t cmd;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  // Controller.
  spmq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath.
  spmq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

>>> rtl/spmq_ctrl.sv
// ----------------------------------------------------------------------------
// Strict priority multi queue controller
// Sequences each request through an execute cycle and a result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strict_priority_multi_queue_unit_defines.svh"

module spmq_ctrl
  import spmq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output spmq_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a new request may enter while the previous result shows.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = start_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    busy_o     = 1'b0;
    done_o     = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      S_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      S_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
    cmd_o.load = start_i && !busy_o;
  end

  // Every execute cycle is followed by exactly one result cycle.
  `SPMQ_ASSERT(a_exec_then_done, clk_i, rst_ni, cmd_o.exec |=> done_o)
  // A result cycle always comes from an execute cycle.
  `SPMQ_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(cmd_o.exec))

endmodule

`default_nettype wire

>>> rtl/spmq_datapath.sv
// ----------------------------------------------------------------------------
// Strict priority multi queue datapath
// Queue pointers, fill counts, task memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strict_priority_multi_queue_unit_defines.svh"

module spmq_datapath
  import spmq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire spmq_cmd_t        cmd_i,
  input  wire spmq_in_t         req_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [CAP_W-1:0] cfg_data_i,
  output spmq_out_t             result_o
);

  localparam logic signed [7:0] QCOUNT_S = 8'(QUEUE_COUNT);

  // Request and configuration registers.
  spmq_in_t           req_q;
  logic [CAP_W-1:0]   cap_q;

  // Queue state.
  logic [PTR_W-1:0]   head_q [QUEUE_COUNT];
  logic [PTR_W-1:0]   tail_q [QUEUE_COUNT];
  logic [CNT_W-1:0]   cnt_q  [QUEUE_COUNT];
  logic [CNT_W-1:0]   cnt_d  [QUEUE_COUNT];
  logic               closed_q, closed_d;

  // Result registers.
  status_e            status_q, status_d;
  logic [QIDX_W-1:0]  qidx_q, qidx_d;
  logic               take_ok_q, take_ok_d;
  logic               drained_q, drained_d;

  // Task memory.
  task_t              mem_q [SLOT_COUNT];
  task_t              rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;

  // Per-queue status and decode.
  logic [QUEUE_COUNT-1:0] full_vec, nonempty_vec, inc_vec, dec_vec;
  logic [CMP_W-1:0]       cap_sat;
  logic [QIDX_W-1:0]      sub_q, take_q;
  logic                   any_ne, all_empty_d;

  // Capture the request at transfer time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(16);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Capacity saturates at the physical queue depth.
  always_comb begin
    cap_sat = CMP_W'(cap_q);
    if (cap_sat > CMP_W'(QUEUE_DEPTH)) cap_sat = CMP_W'(QUEUE_DEPTH);
  end

  // Full and non-empty flags of every queue.
  always_comb begin
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      full_vec[q]     = CMP_W'(cnt_q[q]) >= cap_sat;
      nonempty_vec[q] = cnt_q[q] != '0;
    end
  end

  // Clamp the signed priority into the queue range.
  always_comb begin
    if (req_q.priority_req <= 8'sd0) begin
      sub_q = '0;
    end else if (req_q.priority_req >= QCOUNT_S) begin
      sub_q = QIDX_W'(QUEUE_COUNT - 1);
    end else begin
      sub_q = QIDX_W'(req_q.priority_req);
    end
  end

  // Highest non-empty queue wins a take.
  always_comb begin
    take_q = '0;
    any_ne = 1'b0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      if (nonempty_vec[q]) begin
        take_q = QIDX_W'(q);
        any_ne = 1'b1;
      end
    end
  end

  // Execute decision for the captured request.
  always_comb begin
    status_d  = STAT_DONE;
    qidx_d    = '0;
    take_ok_d = 1'b0;
    closed_d  = closed_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    inc_vec   = '0;
    dec_vec   = '0;
    if (cmd_i.exec) begin
      case (action_e'(req_q.action))
        ACT_SUBMIT: begin
          qidx_d = sub_q;
          if (closed_q) begin
            status_d = STAT_CLOSED;
          end else if (full_vec[sub_q]) begin
            status_d = STAT_FULL;
          end else begin
            mem_we         = 1'b1;
            inc_vec[sub_q] = 1'b1;
          end
        end
        ACT_TAKE: begin
          if (!any_ne) begin
            status_d = STAT_EMPTY;
          end else begin
            qidx_d          = take_q;
            take_ok_d       = 1'b1;
            mem_re          = 1'b1;
            dec_vec[take_q] = 1'b1;
          end
        end
        ACT_CLOSE: begin
          closed_d = 1'b1;
        end
        default: begin
          status_d = STAT_DONE;
        end
      endcase
    end
  end

  // Memory addresses: slot is queue times depth plus pointer.
  assign waddr = ADDR_W'(sub_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[sub_q]);
  assign raddr = ADDR_W'(take_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[take_q]);

  // Next fill counts and the drained flag as seen after this request.
  always_comb begin
    all_empty_d = 1'b1;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      cnt_d[q] = cnt_q[q];
      if (inc_vec[q]) cnt_d[q] = cnt_q[q] + CNT_W'(1);
      if (dec_vec[q]) cnt_d[q] = cnt_q[q] - CNT_W'(1);
      if (cnt_d[q] != '0) all_empty_d = 1'b0;
    end
    drained_d = closed_d && all_empty_d;
  end

  // Pointers, counts and the closed flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
      closed_q <= 1'b0;
    end else begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        cnt_q[q] <= cnt_d[q];
        if (inc_vec[q]) begin
          tail_q[q] <= (tail_q[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : tail_q[q] + PTR_W'(1);
        end
        if (dec_vec[q]) begin
          head_q[q] <= (head_q[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : head_q[q] + PTR_W'(1);
        end
      end
      closed_q <= closed_d;
    end
  end

  // Result registers, loaded in the execute cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= STAT_DONE;
      qidx_q    <= '0;
      take_ok_q <= 1'b0;
      drained_q <= 1'b0;
    end else if (cmd_i.exec) begin
      status_q  <= status_d;
      qidx_q    <= qidx_d;
      take_ok_q <= take_ok_d;
      drained_q <= drained_d;
    end
  end

  // Task memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= '{id: req_q.task_id, wref: req_q.work_ref,
                                  warg: req_q.work_arg};
  end

  // Task memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[raddr];
  end

  // Task fields are zero unless a take handed one out.
  always_comb begin
    result_o.status       = status_q;
    result_o.queue_index  = QOUT_W'(qidx_q);
    result_o.out_task_id  = take_ok_q ? rdata_q.id : '0;
    result_o.out_work_ref = take_ok_q ? rdata_q.wref : '0;
    result_o.out_work_arg = take_ok_q ? rdata_q.warg : '0;
    result_o.drained      = drained_q;
  end

  // Once closed, the unit stays closed.
  `SPMQ_ASSERT(a_closed_sticky, clk_i, rst_ni, $past(closed_q) |-> closed_q)
  // A submit and a take never share an execute cycle.
  `SPMQ_ASSERT_NEVER(a_no_rw_same_cycle, clk_i, rst_ni, mem_we && mem_re)
  // Drained can only be reported by a closed unit.
  `SPMQ_ASSERT(a_drained_closed, clk_i, rst_ni, drained_q |-> closed_q)
  // A successful take always reports done status.
  `SPMQ_ASSERT(a_take_done, clk_i, rst_ni, take_ok_q |-> (status_q == STAT_DONE))

endmodule

`default_nettype wire
